// ===== hdl/text_cell_renderer_defines.svh =====
// ----------------------------------------------------------------------------
// Text cell renderer assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CELL_RENDERER_DEFINES_SVH
`define TEXT_CELL_RENDERER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TCR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("text cell renderer check failed");

// Check that cons holds in the cycle after ante.
`define TCR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("text cell renderer check failed");

`endif

// ===== hdl/tcr_pkg.sv =====
// ----------------------------------------------------------------------------
// Text cell renderer package
// Types, codes, limits and the 5x7 glyph table shared by the renderer modules.
// ----------------------------------------------------------------------------
package tcr_pkg;

	// Glyph geometry and character codes
	localparam int GLYPH_COLUMNS = 5;
	localparam int CELL_ADVANCE  = GLYPH_COLUMNS + 1;
	localparam int GLYPHS        = 95;
	localparam logic [7:0] CHAR_FIRST = 8'd32;
	localparam logic [7:0] CHAR_LAST  = 8'd126;
	localparam logic [7:0] CHAR_LF    = 8'd10;
	localparam logic [7:0] CHAR_CR    = 8'd13;

	// Default limits for the top-level parameters
	localparam int DEF_MAX_WIDTH  = 128;
	localparam int DEF_MAX_PAGES  = 8;
	localparam int DEF_LINE_PITCH = 8;

	// Job queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Operation codes
	localparam logic OP_CHAR   = 1'b0;
	localparam logic OP_CURSOR = 1'b1;

	// Register indexes and reset values
	localparam int REG_IDX_W = 2;
	typedef enum logic [REG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_WRAP   = 2'd2
	} reg_idx_t;

	localparam logic [7:0] RST_WIDTH  = 8'd128;
	localparam logic [6:0] RST_HEIGHT = 7'd64;
	localparam logic       RST_WRAP   = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [7:0] char_code;
		logic [7:0] new_x;
		logic [7:0] new_y;
	} cmd_t;

	typedef struct packed {
		logic [9:0] byte_index;
		logic [7:0] or_mask;
		logic       last;
	} fb_wr_t;

	typedef struct packed {
		logic [7:0] width;
		logic [6:0] height;
		logic       wrap;
	} cfg_t;

	// One printable character, ready for the write sequencer
	typedef struct packed {
		logic [6:0] glyph;
		logic [2:0] shift;
		logic [7:0] col;
		logic [2:0] ncols;
		logic       lo_en;
		logic       hi_en;
		logic [9:0] lo_base;
		logic [9:0] hi_base;
	} job_t;

	// Glyph columns, column 0 in the top byte
	localparam logic [39:0] GLYPH_ROM [0:GLYPHS-1] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700,
		40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
		40'h3649552250, 40'h0005030000, 40'h001C224100,
		40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
		40'h0050300000, 40'h0808080808, 40'h0060600000,
		40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
		40'h4261514946, 40'h2141454B31, 40'h1814127F10,
		40'h2745454539, 40'h3C4A494930, 40'h0171090503,
		40'h3649494936, 40'h064949291E, 40'h0036360000,
		40'h0056360000, 40'h0814224100, 40'h1414141414,
		40'h0041221408, 40'h0201510906, 40'h324979413E,
		40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
		40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
		40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
		40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
		40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
		40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
		40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
		40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
		40'h0708700807, 40'h6151494543, 40'h007F414100,
		40'h0204081020, 40'h0041417F00, 40'h0402010204,
		40'h4040404040, 40'h0001020400, 40'h2054545478,
		40'h7F48444438, 40'h3844444420, 40'h384444487F,
		40'h3854545418, 40'h087E090102, 40'h0C5252523E,
		40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
		40'h7F10284400, 40'h00417F4000, 40'h7C04180478,
		40'h7C08040478, 40'h3844444438, 40'h7C14141408,
		40'h081414187C, 40'h7C08040408, 40'h4854545420,
		40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
		40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
		40'h4464544C44, 40'h0008364100, 40'h00007F0000,
		40'h0041360800, 40'h0201020402
	};

	// Return one glyph column; indexes past the table read as blank
	function automatic logic [7:0] glyph_col(input logic [6:0] g, input logic [2:0] c);
		logic [39:0] cols;
		logic [7:0]  res;
		cols = (g < 7'(GLYPHS)) ? GLYPH_ROM[g] : '0;
		case (c)
			3'd0: res = cols[39:32];
			3'd1: res = cols[31:24];
			3'd2: res = cols[23:16];
			3'd3: res = cols[15:8];
			3'd4: res = cols[7:0];
			default: res = '0;
		endcase
		return res;
	endfunction

endpackage

// ===== hdl/tcr_front.sv =====
// ----------------------------------------------------------------------------
// Text cell renderer front end
// Accepts commands, keeps the cursor and turns each printable character
// into a job for the write sequencer.
// ----------------------------------------------------------------------------
module tcr_front #(
	parameter int MAX_WIDTH  = tcr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_PAGES  = tcr_pkg::DEF_MAX_PAGES,
	parameter int LINE_PITCH = tcr_pkg::DEF_LINE_PITCH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tcr_pkg::cfg_t cfg,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  tcr_pkg::cmd_t cmd,
	input  logic          full,
	output logic          push,
	output tcr_pkg::job_t job
);
	import tcr_pkg::*;

	localparam logic [7:0] MAX_W = 8'(MAX_WIDTH);
	localparam logic [6:0] MAX_H = 7'(MAX_PAGES * 8);

	logic [7:0] col_q, row_q;
	logic [7:0] col_n, row_n;
	logic       accept;
	logic [7:0] w;
	logic [6:0] h;
	logic [7:0] h_sum;
	logic [3:0] pages;
	logic [8:0] nl_sum;
	logic [7:0] nl_row;
	logic       wrap_now;
	logic [7:0] col_e, row_e;
	logic [4:0] page;
	logic [7:0] rem;
	logic [10:0] prod;
	logic       writes;

	assign cmd_stall = full;
	assign accept    = cmd_valid & ~full;

	// Clamp the configured size to the supported limits and derive the page count and newline row
	always_comb begin
		w      = (cfg.width > MAX_W) ? MAX_W : cfg.width;
		h      = (cfg.height > MAX_H) ? MAX_H : cfg.height;
		h_sum  = {1'b0, h} + 8'd7;
		pages  = h_sum[6:3];
		nl_sum = {1'b0, row_q} + 9'(LINE_PITCH);
		nl_row = (nl_sum[7:0] >= {1'b0, h}) ? 8'd0 : nl_sum[7:0];
	end

	// Wrap the line, then lay out the character cell
	always_comb begin
		wrap_now = cfg.wrap && (({1'b0, col_q} + 9'(CELL_ADVANCE)) > {1'b0, w});
		col_e    = wrap_now ? 8'd0 : col_q;
		row_e    = wrap_now ? nl_row : row_q;
		page     = row_e[7:3];

		job.glyph = '0;
		if (cmd.char_code inside {[CHAR_FIRST:CHAR_LAST]}) begin
			job.glyph = 7'(cmd.char_code - CHAR_FIRST);
		end
		job.shift = row_e[2:0];
		job.col   = col_e;
		job.lo_en = {1'b0, page} < {2'b00, pages};
		job.hi_en = (row_e[2:0] != 3'd0) && (({1'b0, page} + 6'd1) < {2'b00, pages});

		rem = w - col_e;
		if (col_e >= w) begin
			job.ncols = 3'd0;
		end else if (rem < 8'(GLYPH_COLUMNS)) begin
			job.ncols = rem[2:0];
		end else begin
			job.ncols = 3'(GLYPH_COLUMNS);
		end

		prod        = 11'(page[2:0]) * 11'(w);
		job.lo_base = prod[9:0];
		job.hi_base = prod[9:0] + 10'(w);
		writes      = (job.ncols != 3'd0) && (job.lo_en || job.hi_en);
	end

	// Decode the command into the next cursor and a possible job
	always_comb begin
		col_n = col_q;
		row_n = row_q;
		push  = 1'b0;
		if (cmd.operation == OP_CURSOR) begin
			col_n = (cmd.new_x < w) ? cmd.new_x : ((w != 8'd0) ? w - 8'd1 : 8'd0);
			row_n = (cmd.new_y < {1'b0, h}) ? cmd.new_y
				: ((h != 7'd0) ? {1'b0, h - 7'd1} : 8'd0);
		end else begin
			case (cmd.char_code)
				CHAR_LF: begin
					col_n = 8'd0;
					row_n = nl_row;
				end
				CHAR_CR: begin
					col_n = 8'd0;
				end
				default: begin
					col_n = col_e + 8'(CELL_ADVANCE);
					row_n = row_e;
					push  = accept && writes;
				end
			endcase
		end
	end

	// Advance the cursor on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_n;
			row_q <= row_n;
		end
	end

endmodule

// ===== hdl/tcr_queue.sv =====
// ----------------------------------------------------------------------------
// Text cell renderer job queue
// Short FIFO that decouples the command front end from the write sequencer.
// ----------------------------------------------------------------------------
module tcr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tcr_pkg::job_t din,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output tcr_pkg::job_t dout
);
	import tcr_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full      = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign dout      = mem_q[rd_ptr_q];

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (PTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/tcr_back.sv =====
// ----------------------------------------------------------------------------
// Text cell renderer write sequencer
// Walks the glyph columns of the head job and issues one framebuffer
// OR-write per cycle through an output register while wr_stall is low.
// ----------------------------------------------------------------------------
module tcr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	input  tcr_pkg::job_t   job,
	output logic            pop,
	output logic            wr_valid,
	input  logic            wr_stall,
	output tcr_pkg::fb_wr_t wr
);
	import tcr_pkg::*;

	logic [2:0]  col_q;
	logic        hi_q;
	logic        wr_valid_q;
	fb_wr_t      wr_q;
	logic        adv, fire;
	logic        cur_hi, is_last;
	logic [15:0] bits;
	logic [9:0]  base;
	fb_wr_t      wr_n;

	assign wr_valid = wr_valid_q;
	assign wr       = wr_q;

	// Pick the current column half and build the write
	always_comb begin
		adv     = ~wr_valid_q | ~wr_stall;
		fire    = job_valid & adv;
		cur_hi  = hi_q | ~job.lo_en;
		is_last = (col_q == 3'(job.ncols - 3'd1)) && (cur_hi || !job.hi_en);
		pop     = fire & is_last;

		bits = {8'd0, glyph_col(job.glyph, col_q)} << job.shift;
		base = cur_hi ? job.hi_base : job.lo_base;

		wr_n.byte_index = base + 10'(job.col) + 10'(col_q);
		wr_n.or_mask    = cur_hi ? bits[15:8] : bits[7:0];
		wr_n.last       = is_last;
	end

	// Advance through columns and halves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			hi_q       <= 1'b0;
			wr_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				wr_valid_q <= 1'b1;
				if (is_last) begin
					col_q <= '0;
					hi_q  <= 1'b0;
				end else if (!cur_hi && job.hi_en) begin
					hi_q <= 1'b1;
				end else begin
					col_q <= col_q + 3'd1;
					hi_q  <= 1'b0;
				end
			end else if (adv) begin
				wr_valid_q <= 1'b0;
			end
		end
	end

	// Load the output payload
	always_ff @(posedge clk) begin
		if (fire) begin
			wr_q <= wr_n;
		end
	end

endmodule

// ===== hdl/text_cell_renderer.sv =====
// ----------------------------------------------------------------------------
// Text cell renderer
// Cursor-tracking 5x7 text renderer that emits OR-writes for a
// page-organized monochrome framebuffer.
// ----------------------------------------------------------------------------
// A command is taken every cycle while the two-entry job queue has room;
// set-cursor, newline, carriage return and fully clipped characters take
// no queue entry and produce no writes. A printable character produces
// up to ten writes (five glyph columns, each a low-page and possibly a
// high-page byte), issued one per cycle while wr_stall is low by the write
// sequencer through its single output register. With the sequencer idle,
// the first write of a character passes through the job queue and then
// the sequencer output register. The configuration port is always ready;
// registers should only change while no writes are outstanding.
module text_cell_renderer #(
	parameter int MAX_WIDTH  = tcr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_PAGES  = tcr_pkg::DEF_MAX_PAGES,
	parameter int LINE_PITCH = tcr_pkg::DEF_LINE_PITCH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_stall,
	input  tcr_pkg::cmd_t                  cmd,
	output logic                           wr_valid,
	input  logic                           wr_stall,
	output tcr_pkg::fb_wr_t                wr,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tcr_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                     cfg_data
);
	import tcr_pkg::*;

	cfg_t cfg_q;
	logic push, full, pop, not_empty;
	job_t job_in, job_head;

	assign cfg_ready = 1'b1;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= RST_WIDTH;
			cfg_q.height <= RST_HEIGHT;
			cfg_q.wrap   <= RST_WRAP;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIDTH:  cfg_q.width  <= cfg_data;
				REG_HEIGHT: cfg_q.height <= cfg_data[6:0];
				REG_WRAP:   cfg_q.wrap   <= cfg_data[0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	tcr_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_PAGES  (MAX_PAGES),
		.LINE_PITCH (LINE_PITCH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.full      (full),
		.push      (push),
		.job       (job_in)
	);

	tcr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (job_in),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.dout      (job_head)
	);

	tcr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (not_empty),
		.job       (job_head),
		.pop       (pop),
		.wr_valid  (wr_valid),
		.wr_stall  (wr_stall),
		.wr        (wr)
	);

endmodule

// ===== hdl/tcr_checker.sv =====
// ----------------------------------------------------------------------------
// Text cell renderer checker
// Port-level assertions on the renderer, attached by bind.
// ----------------------------------------------------------------------------
`include "text_cell_renderer_defines.svh"

module tcr_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            cmd_valid,
	input logic            cmd_stall,
	input logic            wr_valid,
	input logic            wr_stall,
	input tcr_pkg::fb_wr_t wr,
	input logic            cfg_ready
);
	import tcr_pkg::*;

	// A stalled write holds
	`TCR_ASSERT_NEXT(a_wr_hold, wr_valid && wr_stall, wr_valid && $stable(wr))

	// Commands back up only behind pending writes
	`TCR_ASSERT_NOW(a_stall_has_output, cmd_stall || cmd_valid && cmd_stall, wr_valid)

	// No write right after reset
	`TCR_ASSERT_NOW(a_quiet_after_reset, $rose(arst_n), !wr_valid)

	// Configuration never blocks
	`TCR_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready)

endmodule

bind text_cell_renderer tcr_checker u_tcr_checker (.*);
